@@ rtl/tempo_sync_beat_trigger_macros.svh @@
// Assertion macros shared by the tempo-synced trigger RTL.
`ifndef TEMPO_SYNC_BEAT_TRIGGER_MACROS_SVH
`define TEMPO_SYNC_BEAT_TRIGGER_MACROS_SVH

// Implication checked on every rising edge while out of reset.
`define TSBT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true while out of reset.
`define TSBT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/tsbt_pkg.sv @@
// ----------------------------------------------------------------------------
// tsbt_pkg
// Shared widths, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tsbt_pkg;

    localparam int SR_W     = 19;
    localparam int SI_W     = 31;
    localparam int TEMPO_W  = 26;
    localparam int POS_W    = 48;
    localparam int OFF_W    = 12;
    localparam int INT_W    = 31;
    localparam int BPS_W    = 34;
    localparam int DVD_W    = 56;
    localparam int DVS_W    = 34;

    localparam logic [SR_W-1:0] SR_RESET = 19'd48000;
    localparam logic [SI_W-1:0] SI_RESET = 31'd16777216;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_CHECK  = 2'd1;
    localparam logic [1:0] REQ_ARM    = 2'd2;

    localparam logic CFG_SAMPLE_RATE = 1'b0;
    localparam logic CFG_SYNC_INTVL  = 1'b1;

    localparam logic [1:0] DIV_BPS  = 2'd0;
    localparam logic [1:0] DIV_INT  = 2'd1;
    localparam logic [1:0] DIV_CUR  = 2'd2;
    localparam logic [1:0] DIV_PREV = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       apply_update;
        logic       set_manual;
        logic       clr_manual;
        logic       mul_int;
        logic       mul_go;
        logic       div_start;
        logic [1:0] div_sel;
        logic       ld_bps;
        logic       ld_int;
        logic       ld_cur;
        logic       ld_prev;
        logic       clr_dirty;
        logic       trig_clr;
        logic       trig_set;
        logic       trig_eval;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic dirty;
        logic manual;
        logic playing;
        logic tempo_zero;
        logic si_zero;
        logic div_done;
    } sts_t;

endpackage

@@ rtl/tsbt_div.sv @@
// ----------------------------------------------------------------------------
// tsbt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsbt_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsbt_pkg::DVD_W-1:0]  dividend,
    input  logic [tsbt_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [tsbt_pkg::DVD_W-1:0]  quot,
    output logic [tsbt_pkg::DVS_W-1:0]  rem
);
    import tsbt_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             take;

    always_comb
    begin
        shifted = {rem_reg, q_reg[DVD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        take    = (shifted >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            q_reg   <= {q_reg[DVD_W-2:0], take};
            rem_reg <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/tsbt_dp.sv @@
// ----------------------------------------------------------------------------
// tsbt_dp
// Datapath: transport state, configuration, multiplier, divider and result.
// ----------------------------------------------------------------------------
module tsbt_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsbt_pkg::cmd_t                cmd,
    output tsbt_pkg::sts_t                sts,
    input  logic [tsbt_pkg::TEMPO_W-1:0]  tempo,
    input  logic [tsbt_pkg::POS_W-1:0]    beat_position,
    input  logic                          is_playing_in,
    input  logic [tsbt_pkg::OFF_W-1:0]    sample_offset,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [tsbt_pkg::SI_W-1:0]     cfg_data,
    output logic                          trigger,
    output logic [tsbt_pkg::INT_W-1:0]    interval_samples
);
    import tsbt_pkg::*;

    localparam int V_W = 50;

    logic [SR_W-1:0]        sr_reg;
    logic [SI_W-1:0]        si_reg;
    logic                   dirty_reg;
    logic [TEMPO_W-1:0]     tempo_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       prev_pos_reg;
    logic                   playing_reg;
    logic                   manual_reg;
    logic [BPS_W-1:0]       bps_reg;
    logic [INT_W-1:0]       int_reg;
    logic [OFF_W-1:0]       off_reg;
    logic [DVD_W-1:0]       prod_reg;
    logic                   neg_reg;
    logic signed [31:0]     cur_reg;
    logic signed [31:0]     prev_reg;
    logic                   trig_reg;
    logic                   out_trig_reg;
    logic [INT_W-1:0]       out_int_reg;

    logic [24:0]            sr60;
    logic [24:0]            mul_a;
    logic [BPS_W-1:0]       mul_b;
    logic [58:0]            prod;
    logic signed [V_W-1:0]  v_cur;
    logic signed [V_W-1:0]  v_prev;
    logic signed [V_W-1:0]  v_sel;
    logic [V_W-1:0]         v_mag;
    logic [DVD_W-1:0]       dvd;
    logic [DVS_W-1:0]       dvs;
    logic                   div_done;
    logic [DVD_W-1:0]       quot;
    logic [DVS_W-1:0]       rem;
    logic signed [31:0]     rem_s;
    logic                   fire;

    always_comb
    begin
        sr60   = ({6'b0, sr_reg} << 6) - ({6'b0, sr_reg} << 2);
        mul_a  = cmd.mul_int ? sr60 : {13'b0, off_reg};
        mul_b  = cmd.mul_int ? {3'b0, si_reg} : bps_reg;
        prod   = mul_a * mul_b;
        v_cur  = {{2{pos_reg[POS_W-1]}}, pos_reg} + $signed({4'b0, prod_reg[45:0]});
        v_prev = (off_reg == '0) ? $signed({{2{prev_pos_reg[POS_W-1]}}, prev_pos_reg})
                                 : v_cur - $signed({16'b0, bps_reg});
        v_sel  = (cmd.div_sel == DIV_CUR) ? v_cur : v_prev;
        v_mag  = v_sel[V_W-1] ? V_W'(-v_sel) : V_W'(v_sel);
        unique case (cmd.div_sel)
            DIV_BPS:
            begin
                dvd = {22'b0, tempo_reg, 8'b0};
                dvs = {9'b0, sr60};
            end
            DIV_INT:
            begin
                dvd = prod_reg;
                dvs = {tempo_reg, 8'b0};
            end
            default:
            begin
                dvd = {6'b0, v_mag};
                dvs = {3'b0, si_reg};
            end
        endcase
        rem_s = neg_reg ? -$signed({1'b0, rem[30:0]}) : $signed({1'b0, rem[30:0]});
        fire  = (cur_reg < prev_reg)
              || ((off_reg == '0)
                  && ($signed({{4{cur_reg[31]}}, cur_reg}) < $signed({2'b0, bps_reg})));
    end

    tsbt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg       <= SR_RESET;
            si_reg       <= SI_RESET;
            dirty_reg    <= 1'b0;
            tempo_reg    <= '0;
            pos_reg      <= '0;
            prev_pos_reg <= '0;
            playing_reg  <= 1'b0;
            manual_reg   <= 1'b0;
            bps_reg      <= '0;
            int_reg      <= INT_W'(SR_RESET);
            trig_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dirty_reg <= 1'b1;
                if (cfg_index == CFG_SAMPLE_RATE)
                    sr_reg <= cfg_data[SR_W-1:0];
                else
                    si_reg <= cfg_data;
            end
            else if (cmd.clr_dirty)
                dirty_reg <= 1'b0;
            if (cmd.apply_update)
            begin
                tempo_reg    <= tempo;
                prev_pos_reg <= pos_reg;
                pos_reg      <= beat_position;
                playing_reg  <= is_playing_in;
            end
            if (cmd.set_manual)
                manual_reg <= 1'b1;
            else if (cmd.clr_manual)
                manual_reg <= 1'b0;
            if (cmd.ld_bps)
                bps_reg <= (sr_reg == '0) ? '0 : quot[BPS_W-1:0];
            if (cmd.ld_int)
            begin
                if (tempo_reg == '0)
                    int_reg <= INT_W'(sr_reg);
                else if (|quot[DVD_W-1:INT_W])
                    int_reg <= '1;
                else
                    int_reg <= quot[INT_W-1:0];
            end
            if (cmd.trig_set)
                trig_reg <= 1'b1;
            else if (cmd.trig_clr)
                trig_reg <= 1'b0;
            else if (cmd.trig_eval)
                trig_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            off_reg <= sample_offset;
        if (cmd.mul_go)
            prod_reg <= prod[DVD_W-1:0];
        if (cmd.div_start)
            neg_reg <= v_sel[V_W-1];
        if (cmd.ld_cur)
            cur_reg <= rem_s;
        if (cmd.ld_prev)
            prev_reg <= rem_s;
        if (cmd.out_load)
        begin
            out_trig_reg <= trig_reg;
            out_int_reg  <= int_reg;
        end
    end

    assign sts.dirty      = dirty_reg;
    assign sts.manual     = manual_reg;
    assign sts.playing    = playing_reg;
    assign sts.tempo_zero = (tempo_reg == '0);
    assign sts.si_zero    = (si_reg == '0);
    assign sts.div_done   = div_done;

    assign trigger          = out_trig_reg;
    assign interval_samples = out_int_reg;

endmodule

@@ rtl/tsbt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsbt_ctrl
// Sequencer for updates, checks and result hand-off.
// ----------------------------------------------------------------------------
module tsbt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      req_type,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  tsbt_pkg::sts_t  sts,
    output tsbt_pkg::cmd_t  cmd
);
    import tsbt_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_BPS_GO    = 4'd1;
    localparam logic [3:0] S_BPS_WAIT  = 4'd2;
    localparam logic [3:0] S_INT_MUL   = 4'd3;
    localparam logic [3:0] S_INT_GO    = 4'd4;
    localparam logic [3:0] S_INT_WAIT  = 4'd5;
    localparam logic [3:0] S_MUL       = 4'd6;
    localparam logic [3:0] S_CUR_GO    = 4'd7;
    localparam logic [3:0] S_CUR_WAIT  = 4'd8;
    localparam logic [3:0] S_PREV_GO   = 4'd9;
    localparam logic [3:0] S_PREV_WAIT = 4'd10;
    localparam logic [3:0] S_EVAL      = 4'd11;
    localparam logic [3:0] S_OUT       = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       item_reg;
    logic       item_next;
    logic       mv_reg;
    logic       mv_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE) && !sts.dirty;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign m_tvalid = mv_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        item_next  = item_reg;
        mv_next    = (mv_reg && !m_tready);
        cmd.div_sel = DIV_BPS;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sts.dirty)
                begin
                    item_next  = 1'b0;
                    state_next = S_BPS_GO;
                end
                else if (accept)
                begin
                    cmd.load_in  = 1'b1;
                    cmd.trig_clr = 1'b1;
                    item_next    = 1'b1;
                    unique case (req_type)
                        REQ_UPDATE:
                        begin
                            cmd.apply_update = 1'b1;
                            state_next       = S_BPS_GO;
                        end
                        REQ_CHECK:
                        begin
                            if (sts.manual)
                            begin
                                cmd.clr_manual = 1'b1;
                                cmd.trig_set   = 1'b1;
                                state_next     = S_OUT;
                            end
                            else if (!sts.playing || sts.tempo_zero || sts.si_zero)
                                state_next = S_OUT;
                            else
                                state_next = S_MUL;
                        end
                        REQ_ARM:
                        begin
                            cmd.set_manual = 1'b1;
                            state_next     = S_OUT;
                        end
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end
            S_BPS_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_BPS_WAIT;
            end
            S_BPS_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.ld_bps = 1'b1;
                    state_next = S_INT_MUL;
                end
            end
            S_INT_MUL:
            begin
                cmd.mul_int = 1'b1;
                cmd.mul_go  = 1'b1;
                state_next  = S_INT_GO;
            end
            S_INT_GO:
            begin
                cmd.div_sel   = DIV_INT;
                cmd.div_start = 1'b1;
                state_next    = S_INT_WAIT;
            end
            S_INT_WAIT:
            begin
                cmd.div_sel = DIV_INT;
                if (sts.div_done)
                begin
                    cmd.ld_int    = 1'b1;
                    cmd.clr_dirty = 1'b1;
                    state_next    = item_reg ? S_OUT : S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_CUR_GO;
            end
            S_CUR_GO:
            begin
                cmd.div_sel   = DIV_CUR;
                cmd.div_start = 1'b1;
                state_next    = S_CUR_WAIT;
            end
            S_CUR_WAIT:
            begin
                cmd.div_sel = DIV_CUR;
                if (sts.div_done)
                begin
                    cmd.ld_cur = 1'b1;
                    state_next = S_PREV_GO;
                end
            end
            S_PREV_GO:
            begin
                cmd.div_sel   = DIV_PREV;
                cmd.div_start = 1'b1;
                state_next    = S_PREV_WAIT;
            end
            S_PREV_WAIT:
            begin
                cmd.div_sel = DIV_PREV;
                if (sts.div_done)
                begin
                    cmd.ld_prev = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.trig_eval = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                // Hold the result until the output register has room.
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            item_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            item_reg  <= item_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

@@ rtl/tempo_sync_beat_trigger.sv @@
// A check runs two divider passes (for the wrapped positions), an update runs
// the beats-per-sample and interval divides, and arm or idle-transport checks
// skip the divider; one item is in work at a time.
// A configuration write makes the block recompute before it accepts the next
// item. All divides share one one-bit-per-cycle divider.
// Reset (rst_n low, asynchronous) restores sample rate 48000 and a one-beat interval.
// ----------------------------------------------------------------------------
// tempo_sync_beat_trigger
// Tempo-synced beat division trigger with manual one-shot arming.
// ----------------------------------------------------------------------------
`include "tempo_sync_beat_trigger_macros.svh"

module tempo_sync_beat_trigger
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [25:0] tempo, [73:26] beat_position, [74] is_playing_in,
    // [86:75] sample_offset, [87] zero
    input  logic [87:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] trigger, [31:1] interval_samples
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data
);
    import tsbt_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic              trigger;
    logic [INT_W-1:0]  interval_samples;

    tsbt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsbt_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .tempo            (s_tdata[25:0]),
        .beat_position    (s_tdata[73:26]),
        .is_playing_in    (s_tdata[74]),
        .sample_offset    (s_tdata[86:75]),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .trigger          (trigger),
        .interval_samples (interval_samples)
    );

    assign m_tdata = {interval_samples, trigger};

    `TSBT_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && m_tvalid && !m_tready, "result overwritten before it was taken")
    `TSBT_ASSERT(a_one_item, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "second request accepted while one is in work")
    `TSBT_ASSERT(a_arm_sets, clk, rst_n, (s_tvalid && s_tready && (s_tuser == REQ_ARM)) |=> sts.manual, "arm request did not set the manual trigger")

endmodule
